// ----- hdl/wls_pkg.sv -----
//------------------------------------------------------------------------------
// wls_pkg
// Shared constants, command/status structs and arithmetic helpers for the
// weighted list scheduler.
//------------------------------------------------------------------------------
`default_nettype none

package wls_pkg;

   localparam int MAX_TASKS = 64;
   localparam int NUM_CPUS  = 4;

   localparam int ID_W   = 16;
   localparam int LEN_W  = 16;
   localparam int TIME_W = 20;
   localparam int FREE_W = 24;
   localparam int PEN_W  = 31;
   localparam int WGT_W  = 16;
   localparam int CPU_W  = 2;
   localparam int TERM_W = 48;
   localparam int SCORE_W = 32;
   localparam int DIV_W  = 56;
   localparam int ROW_W  = ID_W + LEN_W + 2 * TIME_W;

   localparam int CSR_IDX_W = 3;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_LENGTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_RELEASE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_DUE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_CPU_TIME = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_SLACK    = 3'd4;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
   localparam logic [FREE_W-1:0] FREE_MAX = 24'hFF_FFFF;
   localparam logic [PEN_W-1:0]  PEN_MAX  = 31'h7FFF_FFFF;

   typedef struct packed {
      logic             load;    // store an incoming task
      logic             clear;   // end of set: drop per-set state
      logic             start;   // open a new assignment
      logic             rd;      // read task row at idx
      logic             mul1;
      logic             mul2;
      logic             div_go;
      logic             sum;     // form the four scores
      logic             cmp;     // compare score of lane against best
      logic [CPU_W-1:0] lane;
      logic             fin;     // compute finish time of the winner
      logic             pen;     // tardiness, penalty, result register
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic idx_done;
      logic div_busy;
   } status_type;

   // truncate x / 32768 toward zero
   function automatic logic signed [TERM_W-1:0] trunc_q15(input logic signed [TERM_W-1:0] x);
      logic signed [TERM_W-1:0] t;
      t = x + (x[TERM_W-1] ? TERM_W'(32767) : TERM_W'(0));
      return t >>> 15;
   endfunction

   function automatic logic signed [SCORE_W-1:0] sat32(input logic signed [TERM_W-1:0] x);
      logic signed [TERM_W-1:0] hi;
      logic signed [TERM_W-1:0] lo;
      hi = TERM_W'(SCORE_MAX);
      lo = -hi - TERM_W'(1);
      if (x > hi) begin
         return SCORE_MAX;
      end else if (x < lo) begin
         return SCORE_W'(lo);
      end
      return SCORE_W'(x);
   endfunction

endpackage

`default_nettype wire

// ----- hdl/wls_div.sv -----
//------------------------------------------------------------------------------
// wls_div
// Restoring unsigned divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module wls_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      go,
   input  wire logic [wls_pkg::DIV_W-1:0] dividend,
   input  wire logic [wls_pkg::LEN_W-1:0] divisor,
   output logic                           busy,
   output logic [wls_pkg::DIV_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(wls_pkg::DIV_W);

   logic [wls_pkg::DIV_W-1:0] q_ff, q_in;
   logic [wls_pkg::LEN_W-1:0] rem_ff, rem_in, dvs_ff;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic [wls_pkg::LEN_W:0]   rem_sh;
   logic                      ge;

   always_comb begin
      rem_sh  = {rem_ff, q_ff[wls_pkg::DIV_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (go) begin
         q_in    = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? wls_pkg::LEN_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[wls_pkg::LEN_W-1:0];
         q_in   = {q_ff[wls_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(wls_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (go) begin
         dvs_ff <= (divisor == '0) ? wls_pkg::LEN_W'(1) : divisor;
      end
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// ----- hdl/wls_ctrl.sv -----
//------------------------------------------------------------------------------
// wls_ctrl
// Sequencer: loads tasks, scans unscheduled tasks per assignment, commits the
// winner and hands each result to the output channel.
//------------------------------------------------------------------------------
`default_nettype none

module wls_ctrl #(
   parameter int MAX_TASKS = wls_pkg::MAX_TASKS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tlast,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic [$clog2(MAX_TASKS+1)-1:0] count,
   input  wire wls_pkg::status_type  status,
   output wls_pkg::cmd_type          cmd,
   output logic [$clog2(MAX_TASKS+1)-1:0] idx
);

   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   typedef enum logic [3:0] {
      IDLE, START, SCAN, READ, MUL1, MUL2, DIV, CMP, FIN, PEN, OUT
   } state_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              idx_ff, idx_in, n_ff, n_in;
   logic [wls_pkg::CPU_W-1:0]     lane_ff, lane_in;
   logic                          final_n;

   assign final_n = (CNT_W'(n_ff + CNT_W'(1)) == count);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      n_in     = n_ff;
      lane_in  = lane_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  n_in     = '0;
                  state_in = START;
               end
            end
         end
         START: begin
            cmd.start = 1'b1;
            idx_in    = '0;
            state_in  = SCAN;
         end
         SCAN: begin
            if (idx_ff == count) begin
               state_in = FIN;
            end else if (status.idx_done) begin
               idx_in = idx_ff + CNT_W'(1);
            end else begin
               cmd.rd   = 1'b1;
               state_in = READ;
            end
         end
         READ: begin
            cmd.mul1 = 1'b1;
            state_in = MUL1;
         end
         MUL1: begin
            cmd.mul2 = 1'b1;
            state_in = MUL2;
         end
         MUL2: begin
            cmd.div_go = 1'b1;
            state_in   = DIV;
         end
         DIV: begin
            if (!status.div_busy) begin
               cmd.sum  = 1'b1;
               lane_in  = '0;
               state_in = CMP;
            end
         end
         CMP: begin
            cmd.cmp  = 1'b1;
            cmd.lane = lane_ff;
            lane_in  = lane_ff + wls_pkg::CPU_W'(1);
            if (lane_ff == wls_pkg::CPU_W'(wls_pkg::NUM_CPUS - 1)) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = SCAN;
            end
         end
         FIN: begin
            cmd.fin  = 1'b1;
            state_in = PEN;
         end
         PEN: begin
            cmd.pen  = 1'b1;
            cmd.last = final_n;
            state_in = OUT;
         end
         OUT: begin
            if (rsp_tready) begin
               n_in = n_ff + CNT_W'(1);
               if (final_n) begin
                  cmd.clear = 1'b1;
                  state_in  = IDLE;
               end else begin
                  state_in = START;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         idx_ff   <= '0;
         n_ff     <= '0;
         lane_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         n_ff     <= n_in;
         lane_ff  <= lane_in;
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = (state_ff == OUT);
   assign idx        = idx_ff;

endmodule

`default_nettype wire

// ----- hdl/wls_dp.sv -----
//------------------------------------------------------------------------------
// wls_dp
// Datapath: weight registers, task memory, per-processor score lanes with
// dividers, best-candidate tracking and commit arithmetic.
//------------------------------------------------------------------------------
`default_nettype none

module wls_dp #(
   parameter int MAX_TASKS = wls_pkg::MAX_TASKS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   input  wire logic [wls_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [wls_pkg::WGT_W-1:0]     csr_data,
   input  wire logic [wls_pkg::ROW_W-1:0]     task_row,
   input  wire wls_pkg::cmd_type              cmd,
   input  wire logic [$clog2(MAX_TASKS+1)-1:0] idx,
   output wls_pkg::status_type                status,
   output logic [$clog2(MAX_TASKS+1)-1:0]     count,
   output logic [wls_pkg::ID_W-1:0]           out_task,
   output logic [wls_pkg::CPU_W-1:0]          out_cpu,
   output logic [wls_pkg::FREE_W-1:0]         out_finish,
   output logic [wls_pkg::FREE_W-1:0]         out_tardy,
   output logic [wls_pkg::PEN_W-1:0]          out_penalty,
   output logic                               out_last
);

   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int NC    = wls_pkg::NUM_CPUS;
   localparam int TW    = wls_pkg::TERM_W;

   // configuration
   logic signed [wls_pkg::WGT_W-1:0] wl_ff, wr_ff, wd_ff, wc_ff, ws_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= 16'sd32767;
         wr_ff <= 16'sd32767;
         wd_ff <= 16'sd32767;
         wc_ff <= 16'sd32767;
         ws_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            wls_pkg::REG_WEIGHT_LENGTH:   wl_ff <= csr_data;
            wls_pkg::REG_WEIGHT_RELEASE:  wr_ff <= csr_data;
            wls_pkg::REG_WEIGHT_DUE:      wd_ff <= csr_data;
            wls_pkg::REG_WEIGHT_CPU_TIME: wc_ff <= csr_data;
            wls_pkg::REG_WEIGHT_SLACK:    ws_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // task store
   logic [wls_pkg::ROW_W-1:0]  mem [MAX_TASKS];
   logic [wls_pkg::ROW_W-1:0]  rd_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [wls_pkg::LEN_W-1:0]  maxlen_ff;
   logic [MAX_TASKS-1:0]       done_ff;
   logic                       room;

   assign room = (cnt_ff < CNT_W'(MAX_TASKS));

   always_ff @(posedge clock) begin
      if (cmd.load && room) begin
         mem[cnt_ff[IDX_W-1:0]] <= task_row;
      end
      if (cmd.rd) begin
         rd_ff <= mem[idx[IDX_W-1:0]];
      end
   end

   logic [wls_pkg::ID_W-1:0]   c_id;
   logic [wls_pkg::LEN_W-1:0]  c_len, new_len;
   logic [wls_pkg::TIME_W-1:0] c_rel, c_due;

   assign c_id    = rd_ff[15:0];
   assign c_len   = rd_ff[31:16];
   assign c_rel   = rd_ff[51:32];
   assign c_due   = rd_ff[71:52];
   assign new_len = task_row[31:16];

   // score lanes
   logic [wls_pkg::FREE_W-1:0] cpu_ff [NC];
   logic signed [TW-1:0]       pl_ff, pr_ff, pd_ff, tl_ff, tr_ff, td_ff;
   logic signed [TW-1:0]       pt_ff [NC];
   logic signed [TW-1:0]       tt_ff [NC];
   logic signed [TW-1:0]       lin_ff [NC];
   logic [39:0]                sp1_ff [NC];
   logic                       neg_ff [NC];
   logic [wls_pkg::DIV_W-1:0]  sp2_ff [NC];
   logic signed [wls_pkg::SCORE_W-1:0] score_ff [NC];
   logic [NC-1:0]              busy;
   logic [wls_pkg::DIV_W-1:0]  quo [NC];
   logic [wls_pkg::WGT_W-1:0]  ws_mag;

   assign ws_mag = ws_ff[15] ? wls_pkg::WGT_W'(-{ws_ff[15], ws_ff}) : ws_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         pl_ff <= TW'($signed({1'b0, c_len}) * wl_ff);
         pr_ff <= TW'($signed({1'b0, c_rel}) * wr_ff);
         pd_ff <= TW'($signed({1'b0, c_due}) * wd_ff);
      end
      if (cmd.mul2) begin
         tl_ff <= wls_pkg::trunc_q15(pl_ff);
         tr_ff <= wls_pkg::trunc_q15(pr_ff);
         td_ff <= wls_pkg::trunc_q15(pd_ff);
      end
   end

   for (genvar c = 0; c < NC; c++) begin : g_lane
      logic signed [wls_pkg::FREE_W:0] dt;
      logic [wls_pkg::FREE_W-1:0]      dt_mag;
      logic signed [TW-1:0]            slack;
      logic [40:0]                     q_sh;

      assign dt     = $signed({5'b0, c_due}) - $signed({1'b0, cpu_ff[c]});
      assign dt_mag = dt[wls_pkg::FREE_W] ? wls_pkg::FREE_W'(-dt) : dt[wls_pkg::FREE_W-1:0];
      assign q_sh   = quo[c][wls_pkg::DIV_W-1:15];
      assign slack  = neg_ff[c] ? -TW'({7'b0, q_sh}) : TW'({7'b0, q_sh});

      always_ff @(posedge clock) begin
         if (cmd.mul1) begin
            pt_ff[c]  <= TW'($signed({1'b0, cpu_ff[c]}) * wc_ff);
            sp1_ff[c] <= maxlen_ff * dt_mag;
            neg_ff[c] <= dt[wls_pkg::FREE_W] ^ ws_ff[15];
         end
         if (cmd.mul2) begin
            tt_ff[c]  <= wls_pkg::trunc_q15(pt_ff[c]);
            sp2_ff[c] <= wls_pkg::DIV_W'(sp1_ff[c] * ws_mag);
         end
         lin_ff[c] <= tl_ff + tr_ff + td_ff + tt_ff[c];
         if (cmd.sum) begin
            score_ff[c] <= wls_pkg::sat32(lin_ff[c] + slack);
         end
      end

      wls_div u_div (
         .clock    (clock),
         .reset    (reset),
         .go       (cmd.div_go),
         .dividend (sp2_ff[c]),
         .divisor  (c_len),
         .busy     (busy[c]),
         .quotient (quo[c])
      );
   end

   // best candidate of the current assignment
   logic                              found_ff;
   logic signed [wls_pkg::SCORE_W-1:0] best_ff;
   logic [IDX_W-1:0]                  bi_ff;
   logic [wls_pkg::CPU_W-1:0]         bc_ff;
   logic [wls_pkg::ID_W-1:0]          b_id_ff;
   logic [wls_pkg::LEN_W-1:0]         b_len_ff;
   logic [wls_pkg::TIME_W-1:0]        b_rel_ff, b_due_ff;
   logic [wls_pkg::FREE_W-1:0]        fin_ff, base, fin;
   logic [wls_pkg::FREE_W:0]          fsum;
   logic [wls_pkg::FREE_W-1:0]        tard;
   logic [wls_pkg::PEN_W:0]           psum;
   logic [wls_pkg::PEN_W-1:0]         pen_ff, pen_in;

   always_comb begin
      base = (cpu_ff[bc_ff] >= {4'b0, b_rel_ff}) ? cpu_ff[bc_ff] : {4'b0, b_rel_ff};
      fsum = {1'b0, base} + {9'b0, b_len_ff};
      fin  = fsum[wls_pkg::FREE_W] ? wls_pkg::FREE_MAX : fsum[wls_pkg::FREE_W-1:0];
      tard = (fin_ff > {4'b0, b_due_ff}) ? (fin_ff - {4'b0, b_due_ff}) : '0;
      psum = {1'b0, pen_ff} + {8'b0, tard};
      pen_in = (psum > {1'b0, wls_pkg::PEN_MAX}) ? wls_pkg::PEN_MAX
                                                 : psum[wls_pkg::PEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         best_ff  <= wls_pkg::SCORE_MAX;
      end
      if (cmd.sum && !found_ff) begin
         bi_ff    <= idx[IDX_W-1:0];
         bc_ff    <= '0;
         b_id_ff  <= c_id;
         b_len_ff <= c_len;
         b_rel_ff <= c_rel;
         b_due_ff <= c_due;
      end
      if (cmd.cmp && (score_ff[cmd.lane] < best_ff)) begin
         best_ff  <= score_ff[cmd.lane];
         bi_ff    <= idx[IDX_W-1:0];
         bc_ff    <= cmd.lane;
         b_id_ff  <= c_id;
         b_len_ff <= c_len;
         b_rel_ff <= c_rel;
         b_due_ff <= c_due;
      end
      if (cmd.fin) begin
         fin_ff <= fin;
      end
      if (cmd.pen) begin
         out_task    <= b_id_ff;
         out_cpu     <= bc_ff;
         out_finish  <= fin_ff;
         out_tardy   <= tard;
         out_penalty <= pen_in;
         out_last    <= cmd.last;
      end
   end

   // per-set control state
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         found_ff  <= 1'b0;
         cnt_ff    <= '0;
         maxlen_ff <= '0;
         done_ff   <= '0;
         pen_ff    <= '0;
         for (int k = 0; k < NC; k++) begin
            cpu_ff[k] <= '0;
         end
      end else begin
         if (cmd.start) begin
            found_ff <= 1'b0;
         end else if (cmd.sum) begin
            found_ff <= 1'b1;
         end
         if (cmd.load && room) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (new_len > maxlen_ff) begin
               maxlen_ff <= new_len;
            end
         end
         if (cmd.fin) begin
            cpu_ff[bc_ff]  <= fin;
            done_ff[bi_ff] <= 1'b1;
         end
         if (cmd.pen) begin
            pen_ff <= pen_in;
         end
      end
   end

   assign status.idx_done = done_ff[idx[IDX_W-1:0]];
   assign status.div_busy = |busy;
   assign count           = cnt_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_TASKS))
      else $error("task count above store depth");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (cnt_ff == '0) && (pen_ff == '0) && (done_ff == '0))
      else $error("set state not cleared");

   a_fin_len: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> fin_ff >= {8'b0, b_len_ff})
      else $error("finish time below task length");

   a_pen_mono: assert property (@(posedge clock) disable iff (reset)
      !cmd.clear |=> pen_ff >= $past(pen_ff))
      else $error("penalty decreased within a set");

endmodule

`default_nettype wire

// ----- hdl/weighted_list_scheduler_4cpu.sv -----
//------------------------------------------------------------------------------
// weighted_list_scheduler_4cpu
// Loads a set of tasks, then assigns them one by one to four processors by a
// weighted score and reports finish time, tardiness and running penalty.
//------------------------------------------------------------------------------
//  channel  direction  payload
//  req_     in         task_number, proc_time, release_time, due_time; tlast
//  rsp_     out        sched_task, processor, finish_time, tardiness,
//                      total_penalty; tlast = last_result
//  csr_     in         index 0..4 selects a Q1.15 weight, data = weight
//
//  req_tready is high only while idle.
//  Each assignment scans every unscheduled task: a read, two multiply steps,
//  the 56-step restoring dividers (one per processor, run in parallel), the
//  score sum and one compare per processor; then finish, penalty and output.
//  Each result waits in the output register until rsp_tready; the scan holds.
//  Reset is synchronous and clears the set state; weights return to defaults.
//------------------------------------------------------------------------------
`default_nettype none

module weighted_list_scheduler_4cpu #(
   parameter int MAX_TASKS = wls_pkg::MAX_TASKS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // task_number, proc_time, release_time, due_time
   input  wire logic        req_tlast,  // last_task
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [103:0]     rsp_tdata,  // sched_task, processor, finish_time, tardiness,
                                        // total_penalty, zero fill
   output logic             rsp_tlast,  // last_result
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [wls_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [wls_pkg::WGT_W-1:0]     csr_data
);

   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   wls_pkg::cmd_type          cmd;
   wls_pkg::status_type       status;
   logic [CNT_W-1:0]          idx, count;
   logic [wls_pkg::ID_W-1:0]  out_task;
   logic [wls_pkg::CPU_W-1:0] out_cpu;
   logic [wls_pkg::FREE_W-1:0] out_finish, out_tardy;
   logic [wls_pkg::PEN_W-1:0] out_penalty;

   // weights are taken at any time; the user must write them only while idle, as the block does not enforce it
   assign csr_ready = 1'b1;

   wls_ctrl #(.MAX_TASKS(MAX_TASKS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .count      (count),
      .status     (status),
      .cmd        (cmd),
      .idx        (idx)
   );

   wls_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .task_row    (req_tdata),
      .cmd         (cmd),
      .idx         (idx),
      .status      (status),
      .count       (count),
      .out_task    (out_task),
      .out_cpu     (out_cpu),
      .out_finish  (out_finish),
      .out_tardy   (out_tardy),
      .out_penalty (out_penalty),
      .out_last    (rsp_tlast)
   );

   // pack result fields from the lowest bit up
   assign rsp_tdata = {7'b0, out_penalty, out_tardy, out_finish, out_cpu, out_task};

endmodule

`default_nettype wire

// ----- verif/wls_checker.sv -----
//------------------------------------------------------------------------------
// wls_checker
// Watches the task, result and weight channels of the scheduler, predicts every
// assignment of a task set from the loaded tasks and the current weights, and
// compares each result transfer field by field against the oldest prediction.
//------------------------------------------------------------------------------
module wls_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [71:0]  req_tdata,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   input  logic         rsp_tlast,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [wls_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wls_pkg::WGT_W-1:0]     csr_data,
   output int           failures,
   output int           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [wls_pkg::ID_W-1:0]   task_id;
      logic [wls_pkg::CPU_W-1:0]  cpu;
      logic [wls_pkg::FREE_W-1:0] finish;
      logic [wls_pkg::FREE_W-1:0] tardy;
      logic [wls_pkg::PEN_W-1:0]  penalty;
      logic                       last;
   } assignment_type;

   assignment_type planned_q[$];

   logic [wls_pkg::ID_W-1:0]   ids      [wls_pkg::MAX_TASKS];
   logic [wls_pkg::LEN_W-1:0]  lengths  [wls_pkg::MAX_TASKS];
   logic [wls_pkg::TIME_W-1:0] releases [wls_pkg::MAX_TASKS];
   logic [wls_pkg::TIME_W-1:0] dues     [wls_pkg::MAX_TASKS];
   logic                       placed   [wls_pkg::MAX_TASKS];
   logic [wls_pkg::FREE_W-1:0] cpu_free [wls_pkg::NUM_CPUS];
   logic [wls_pkg::LEN_W-1:0]  longest;
   logic [wls_pkg::PEN_W-1:0]  pen_total;
   int                         held;
   logic signed [wls_pkg::WGT_W-1:0] weights [5];

   assign outstanding = planned_q.size();

   function automatic longint task_cost(int i, int c);
      longint p, r, d, t, dv, acc;
      longint wl, wr, wd, wc, ws;
      p  = longint'(lengths[i]);
      r  = longint'(releases[i]);
      d  = longint'(dues[i]);
      t  = longint'(cpu_free[c]);
      dv = (p != 0) ? p : 1;
      wl = longint'(weights[0]);
      wr = longint'(weights[1]);
      wd = longint'(weights[2]);
      wc = longint'(weights[3]);
      ws = longint'(weights[4]);
      acc = p * wl / 32768 + r * wr / 32768 + d * wd / 32768 + t * wc / 32768;
      acc += longint'(longest) * (d - t) * ws / (dv * 32768);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      return acc;
   endfunction

   task automatic clear_set();
      for (int k = 0; k < wls_pkg::MAX_TASKS; k++) placed[k] = 1'b0;
      for (int k = 0; k < wls_pkg::NUM_CPUS; k++) cpu_free[k] = '0;
      longest   = '0;
      pen_total = '0;
      held      = 0;
   endtask

   // run the whole list schedule of the held set and queue its results
   task automatic plan_set();
      longint best, s;
      int bi, bc;
      bit found;
      longint fin, tard, pen;
      assignment_type a;
      for (int n = 0; n < held; n++) begin
         best  = 64'sd2147483647;
         found = 0;
         bi    = 0;
         bc    = 0;
         for (int i = 0; i < held; i++) begin
            if (placed[i]) continue;
            if (!found) begin
               found = 1;
               bi = i;
               bc = 0;
            end
            for (int c = 0; c < wls_pkg::NUM_CPUS; c++) begin
               s = task_cost(i, c);
               if (s < best) begin
                  best = s;
                  bi = i;
                  bc = c;
               end
            end
         end
         placed[bi] = 1'b1;
         fin = longint'(cpu_free[bc]);
         if (fin < longint'(releases[bi])) fin = longint'(releases[bi]);
         fin += longint'(lengths[bi]);
         if (fin > 64'sd16777215) fin = 64'sd16777215;
         cpu_free[bc] = wls_pkg::FREE_W'(fin);
         tard = (fin > longint'(dues[bi])) ? fin - longint'(dues[bi]) : 64'sd0;
         pen  = longint'(pen_total) + tard;
         if (pen > 64'sd2147483647) pen = 64'sd2147483647;
         pen_total  = wls_pkg::PEN_W'(pen);
         a.task_id  = ids[bi];
         a.cpu      = wls_pkg::CPU_W'(bc);
         a.finish   = wls_pkg::FREE_W'(fin);
         a.tardy    = wls_pkg::FREE_W'(tard);
         a.penalty  = wls_pkg::PEN_W'(pen);
         a.last     = (n + 1 == held);
         planned_q.insert(planned_q.size(), a);
      end
      clear_set();
   endtask

   always @(posedge clock) begin
      assignment_type a;
      int errs;
      errs = 0;
      if (reset) begin
         clear_set();
         planned_q.delete();
         failures <= 0;
         weights[0] = 16'sd32767;
         weights[1] = 16'sd32767;
         weights[2] = 16'sd32767;
         weights[3] = 16'sd32767;
         weights[4] = 16'sd0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               wls_pkg::REG_WEIGHT_LENGTH:   weights[0] = csr_data;
               wls_pkg::REG_WEIGHT_RELEASE:  weights[1] = csr_data;
               wls_pkg::REG_WEIGHT_DUE:      weights[2] = csr_data;
               wls_pkg::REG_WEIGHT_CPU_TIME: weights[3] = csr_data;
               wls_pkg::REG_WEIGHT_SLACK:    weights[4] = csr_data;
               default: ;  // unknown index: drop
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (held < wls_pkg::MAX_TASKS) begin
               ids[held]      = req_tdata[15:0];
               lengths[held]  = req_tdata[31:16];
               releases[held] = req_tdata[51:32];
               dues[held]     = req_tdata[71:52];
               if (req_tdata[31:16] > longest) longest = req_tdata[31:16];
               held++;
            end
            if (req_tlast) plan_set();
         end
         if (rsp_tvalid && rsp_tready) begin
            if (planned_q.size() == 0) begin
               $error("result transfer with no assignment expected");
               errs++;
            end else begin
               a = planned_q.pop_front();
               if (rsp_tdata[15:0] !== a.task_id) begin
                  $error("sched_task expected %0d actual %0d", a.task_id, rsp_tdata[15:0]);
                  errs++;
               end
               if (rsp_tdata[17:16] !== a.cpu) begin
                  $error("processor expected %0d actual %0d", a.cpu, rsp_tdata[17:16]);
                  errs++;
               end
               if (rsp_tdata[41:18] !== a.finish) begin
                  $error("finish_time expected %0d actual %0d", a.finish, rsp_tdata[41:18]);
                  errs++;
               end
               if (rsp_tdata[65:42] !== a.tardy) begin
                  $error("tardiness expected %0d actual %0d", a.tardy, rsp_tdata[65:42]);
                  errs++;
               end
               if (rsp_tdata[96:66] !== a.penalty) begin
                  $error("total_penalty expected %0d actual %0d", a.penalty,
                         rsp_tdata[96:66]);
                  errs++;
               end
               if (rsp_tlast !== a.last) begin
                  $error("last_result expected %0d actual %0d", a.last, rsp_tlast);
                  errs++;
               end
            end
         end
         if (errs != 0) begin
            failures <= failures + errs;
         end
      end
   end

endmodule

// ----- verif/testbench.sv -----
//------------------------------------------------------------------------------
// testbench
// Drives task sets and weight settings into the four-processor list scheduler
// and lets the checker predict and compare every assignment result.
//------------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // index past the weight registers; writes there must be ignored
   localparam logic [wls_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   // cycles without any transfer before the run is declared hung; the longest
   // legal gap is one assignment scan over a full store
   localparam int STALL_LIMIT = 40000;
   // settle time after the last result before a weight write or the verdict
   localparam int SETTLE = 200;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [71:0]   req_tdata = '0;  // task_number, proc_time, release_time, due_time
   logic          req_tlast = 0;   // last_task
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [103:0]  rsp_tdata;       // sched_task, processor, finish_time, tardiness,
                                   // total_penalty, zero fill
   logic          rsp_tlast;       // last_result
   logic          csr_valid = 0;
   logic          csr_ready;
   logic [wls_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [wls_pkg::WGT_W-1:0]     csr_data = '0;

   int  failures;
   int  outstanding;
   int  quiet_cycles;
   bit  quiet = 0;      // hold both sides busy, no idling

   always #5 clock = ~clock;

   weighted_list_scheduler_4cpu dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   wls_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .failures, .outstanding
   );

   // result side: stall at random, with odds of 7 in 100, unless in the quiet stretch
   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= 7);
   end

   // watchdog: count cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("weighted_list_scheduler_4cpu test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // transfer one task; keep tvalid high when no idle cycle is taken
   task automatic send_task(input logic [15:0] id, input logic [15:0] len,
                            input logic [19:0] rel, input logic [19:0] due,
                            input bit last);
      if (!quiet && $urandom_range(0, 99) < 7) begin
         req_tvalid <= 0;
         do @(posedge clock); while ($urandom_range(0, 99) < 30);
      end
      req_tvalid <= 1;
      req_tdata  <= {due, rel, len, id};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // drop tvalid and wait for the set in flight to drain
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [wls_pkg::CSR_IDX_W-1:0] idx,
                            input logic [wls_pkg::WGT_W-1:0] val);
      if (!quiet && $urandom_range(0, 99) < 7) @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic write_weights(input logic [wls_pkg::WGT_W-1:0] wl,
                                input logic [wls_pkg::WGT_W-1:0] wr,
                                input logic [wls_pkg::WGT_W-1:0] wd,
                                input logic [wls_pkg::WGT_W-1:0] wc,
                                input logic [wls_pkg::WGT_W-1:0] ws);
      write_reg(wls_pkg::REG_WEIGHT_LENGTH, wl);
      write_reg(wls_pkg::REG_WEIGHT_RELEASE, wr);
      write_reg(wls_pkg::REG_WEIGHT_DUE, wd);
      write_reg(wls_pkg::REG_WEIGHT_CPU_TIME, wc);
      write_reg(wls_pkg::REG_WEIGHT_SLACK, ws);
   endtask

   // one set of n random tasks, the last one marked; times either span the
   // full range or crowd together so tardiness shows up
   task automatic random_set(input int n);
      logic [15:0] len;
      logic [19:0] rel, due;
      bit tight;
      tight = 1'($urandom_range(0, 1));
      for (int k = 0; k < n; k++) begin
         len = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom);
         if (tight) begin
            len = {8'd0, len[7:0]};
            rel = 20'($urandom_range(0, 2000));
            due = 20'($urandom_range(0, 3000));
         end else begin
            rel = 20'($urandom);
            due = 20'($urandom);
         end
         send_task(16'($urandom), len, rel, due, k == n - 1);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;

      // directed: field extremes and a zero length under reset weights
      send_task(16'h0000, 16'd1, 20'h00000, 20'h00000, 0);
      send_task(16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 0);
      send_task(16'h5A5A, 16'h0000, 20'h00010, 20'h00005, 0);
      send_task(16'hA5A5, 16'h8000, 20'h80000, 20'h7FFFF, 1);
      send_task(16'h1234, 16'd7, 20'd3, 20'd2, 1);  // single-task set
      drain();

      // extreme weights, each register written; an unused index is ignored
      write_weights(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      write_reg(REG_UNUSED, 16'h1111);
      send_task(16'd1, 16'hFFFF, 20'hFFFFF, 20'd0, 0);
      send_task(16'd2, 16'd1, 20'd0, 20'hFFFFF, 0);
      send_task(16'd3, 16'd0, 20'd100, 20'd50, 1);
      drain();
      write_weights(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_task(16'd4, 16'hFFFF, 20'd0, 20'hFFFFF, 0);
      send_task(16'd5, 16'd1, 20'hFFFFF, 20'hFFFFF, 0);
      send_task(16'd6, 16'd2, 20'd9, 20'd1, 1);
      drain();

      // store full: 64 held, then two dropped, the second closing the set
      write_weights(16'd0, 16'd0, 16'd0, 16'd0, 16'h4000);
      quiet = 1;
      random_set(66);
      drain();
      quiet = 0;

      // random sets across several weight settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_weights(16'd0, 16'd0, 16'd0, 16'd0, 16'h0000);
            1: write_weights(16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000);
            default: write_weights(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom), 16'($urandom));
         endcase
         for (int s = 0; s < 3; s++) random_set($urandom_range(1, 6));
         drain();
      end

      if (failures == 0) begin
         $display("weighted_list_scheduler_4cpu test passed");
      end else begin
         $display("weighted_list_scheduler_4cpu test failed");
      end
      $finish;
   end

endmodule
